// ===== src/plcg_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// plcg_pkg
// shared types and constants of the piecewise linear color gradient
// ---------------------------------------------------------------------------
package plcg_pkg;
    localparam int MAX_STOPS_DEF = 16;
    localparam int POS_W = 17;
    localparam int CH_W = 16;
    localparam int FRAC_W = 16;
    localparam int CNT_W = 4;
    localparam logic [POS_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [0:0] ADDR_INTERIOR = 1'b0;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } color_t;

    // one classified request from the front to the back
    typedef struct packed {
        logic             eval;
        logic [7:0]       idx;
        logic [POS_W-1:0] pos;
        color_t           color;
    } req_t;
endpackage
`default_nettype wire

// ===== src/plcg_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// plcg_queue
// two-entry request queue between front and back
// ---------------------------------------------------------------------------
module plcg_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire plcg_pkg::req_t  in_req,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output plcg_pkg::req_t       out_req
);
    plcg_pkg::req_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_req   = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== src/plcg_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// plcg_back
// stop table, segment scan, fraction divider and color blend
// ---------------------------------------------------------------------------
module plcg_back #(
    parameter int MAX_STOPS = plcg_pkg::MAX_STOPS_DEF,
    parameter int IDX_W = $clog2(MAX_STOPS)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [plcg_pkg::CNT_W-1:0] interior_stops,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire plcg_pkg::req_t             req,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [55:0]                     m_tdata
);
    localparam int PW = plcg_pkg::POS_W;
    localparam int CW = plcg_pkg::CH_W;
    localparam logic [IDX_W:0] MAX_N = (IDX_W+1)'(MAX_STOPS - 2);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [PW-1:0]       pos_mem [MAX_STOPS];
    plcg_pkg::color_t    col_mem [MAX_STOPS];

    logic [2:0]          state_reg;
    logic [IDX_W:0]      j_reg, last_reg;
    logic [PW-1:0]       t_reg, left_reg, right_reg, pos_rd_reg;
    logic [PW-1:0]       num_reg, den_reg;
    logic [PW-1:0]       rem_reg;
    logic [4:0]          bit_reg;
    logic [plcg_pkg::FRAC_W:0] tn_reg;
    logic                zero_reg;
    plcg_pkg::color_t    cl_reg, cr_reg;
    logic [2*CW+1:0]     acc_r_reg, acc_g_reg, acc_b_reg;
    logic [55:0]         out_reg;
    logic                out_valid_reg;

    logic [IDX_W:0]      n_sat;
    logic [PW-1:0]       right_pos;
    logic [PW-1:0]       diff;
    logic [PW:0]         rem_sh;
    logic                fire;

    assign n_sat = ({1'b0, interior_stops} > MAX_N) ? MAX_N
                 : (IDX_W+1)'(interior_stops);
    assign right_pos = (j_reg + 1'b1 == last_reg) ? plcg_pkg::ONE_Q16 : pos_rd_reg;
    assign diff = t_reg - left_reg;
    assign rem_sh = {rem_reg, num_reg[PW-1]};
    assign fire = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    function automatic logic [2*CW+1:0] blend(
        input logic [CW-1:0] cl, input logic [CW-1:0] cr,
        input logic [plcg_pkg::FRAC_W:0] tn);
        blend = cl * (17'h10000 - tn) + cr * tn + 34'd32768;
    endfunction

    // stop table: one write port, registered reads
    always_ff @(posedge aclk) begin
        if (fire && !req.eval && {1'b0, req.idx} < 9'(MAX_STOPS)) begin
            pos_mem[req.idx[IDX_W-1:0]] <= req.pos;
            col_mem[req.idx[IDX_W-1:0]] <= req.color;
        end
        pos_rd_reg <= pos_mem[IDX_W'(j_reg + 1'b1)];
        cl_reg     <= col_mem[j_reg[IDX_W-1:0]];
        cr_reg     <= col_mem[IDX_W'(j_reg + 1'b1)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (fire && req.eval) begin
                        t_reg <= req.pos;
                        last_reg <= n_sat + 1'b1;
                        j_reg <= '0;
                        left_reg <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_SCAN;
                ST_SCAN: begin
                    if (t_reg >= left_reg && t_reg <= right_pos) begin
                        zero_reg <= right_pos == left_reg;
                        // dividend is diff * 65536; its top sixteen quotient bits are
                        // zero, so start with diff >> 1 already in the remainder
                        num_reg <= diff << (PW-1);
                        den_reg <= right_pos - left_reg;
                        rem_reg <= diff >> 1;
                        tn_reg <= '0;
                        bit_reg <= 5'd0;
                        state_reg <= ST_DIV;
                    end else if (j_reg + 1'b1 == last_reg) begin
                        out_reg <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        left_reg <= right_pos;
                        j_reg <= j_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_DIV: begin
                    // restoring division, one quotient bit a cycle, 17 bits
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_reg <= PW'(rem_sh - {1'b0, den_reg});
                        tn_reg <= {tn_reg[plcg_pkg::FRAC_W-1:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[PW-1:0];
                        tn_reg <= {tn_reg[plcg_pkg::FRAC_W-1:0], 1'b0};
                    end
                    num_reg <= {num_reg[PW-2:0], 1'b0};
                    bit_reg <= bit_reg + 1'b1;
                    if (zero_reg || bit_reg == 5'd16) state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    acc_r_reg <= blend(cl_reg.red, cr_reg.red, tn_reg);
                    acc_g_reg <= blend(cl_reg.green, cr_reg.green, tn_reg);
                    acc_b_reg <= blend(cl_reg.blue, cr_reg.blue, tn_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (zero_reg) begin
                        out_reg <= {7'd0, 1'b1, cl_reg.blue, cl_reg.green, cl_reg.red};
                    end else begin
                        out_reg <= {7'd0, 1'b1, acc_b_reg[31:16], acc_g_reg[31:16],
                                    acc_r_reg[31:16]};
                    end
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/plcg_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// plcg_front
// accepts stream items and classifies them into queue requests
// ---------------------------------------------------------------------------
module plcg_front (
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [87:0]  s_tdata,
    input  wire logic         s_tuser,
    output logic              q_valid,
    input  wire logic         q_ready,
    output plcg_pkg::req_t    q_req
);
    assign q_valid = s_tvalid;
    assign s_tready = q_ready;
    always_comb begin
        q_req.eval = s_tuser == plcg_pkg::ACT_EVAL;
        q_req.idx = {4'd0, s_tdata[3:0]};
        q_req.pos = (s_tuser == plcg_pkg::ACT_EVAL) ? s_tdata[85:69] : s_tdata[20:4];
        q_req.color.red = s_tdata[36:21];
        q_req.color.green = s_tdata[52:37];
        q_req.color.blue = s_tdata[68:53];
    end
endmodule
`default_nettype wire

// ===== src/piecewise_linear_color_gradient.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// piecewise_linear_color_gradient
// color gradient evaluator over up to MAX_STOPS color stops
// ---------------------------------------------------------------------------
// Write requests (tuser 0) load a stop position and color into the back end's
// stop table; evaluate requests (tuser 1) scan segments, each with a table
// read and a bracket compare, run a restoring divider for the fraction (cut
// short for a zero-width segment), then a blend and an output step. The back
// end handles one request at a time; the two-entry queue lets the input side
// keep taking requests meanwhile until it fills, and the result register holds
// a result until it is taken.
module piecewise_linear_color_gradient #(
    parameter int MAX_STOPS = plcg_pkg::MAX_STOPS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // stop_index, stop_position, stop_red, stop_green, stop_blue, query_param
    input  wire logic [87:0] s_tdata,
    // action
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // red_out, green_out, blue_out, found
    output logic [55:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [plcg_pkg::CNT_W-1:0] interior_reg;
    logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    plcg_pkg::req_t q_in_req, q_out_req;

    // config register, only register 0 exists
    assign pready = 1'b1;
    assign prdata = (paddr == plcg_pkg::ADDR_INTERIOR) ? {28'd0, interior_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interior_reg <= '0;
        end else if (psel && penable && pwrite && paddr == plcg_pkg::ADDR_INTERIOR) begin
            interior_reg <= pwdata[3:0];
        end
    end

    plcg_front u_front (
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_valid(q_in_valid), .q_ready(q_in_ready), .q_req(q_in_req)
    );

    plcg_queue u_queue (
        .aclk, .aresetn,
        .in_valid(q_in_valid), .in_ready(q_in_ready), .in_req(q_in_req),
        .out_valid(q_out_valid), .out_ready(q_out_ready), .out_req(q_out_req)
    );

    plcg_back #(.MAX_STOPS(MAX_STOPS)) u_back (
        .aclk, .aresetn,
        .interior_stops(interior_reg),
        .req_valid(q_out_valid), .req_ready(q_out_ready), .req(q_out_req),
        .m_tvalid, .m_tready, .m_tdata
    );
endmodule
`default_nettype wire
